// ----- rtl/esc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Constants for the seconds-to-calendar pipeline: reciprocals for the
// constant divisions, calendar offsets and the month start table.
// ----------------------------------------------------------------------------
package esc_pkg;

   // number of register stages between request and response
   localparam int NUM_STAGES = 11;

   // time units
   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [6:0]  SECS_PER_MIN  = 7'd60;

   // reciprocals: floor(2^35/675), floor(2^20/225), floor(2^26/1461), floor(2^16/15)
   localparam logic [25:0] RECIP_DAY   = 26'd50903316;
   localparam logic [12:0] RECIP_HOUR  = 13'd4660;
   localparam logic [15:0] RECIP_QUAD  = 16'd45933;
   localparam logic [12:0] RECIP_MIN   = 13'd4369;

   // four-year cycles are counted from 1968, the leap year before the epoch
   localparam logic [11:0] BASE_YEAR      = 12'd1968;
   localparam logic [15:0] BASE_OFFSET    = 16'd731;
   localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
   // first day (from the epoch) of March 2100, a skipped leap day
   localparam logic [15:0] SKIP_LEAP_DAY  = 16'd47541;

   // day-of-year offsets within a four-year cycle
   localparam logic [10:0] QUAD_YEAR1 = 11'd366;
   localparam logic [10:0] QUAD_YEAR2 = 11'd731;
   localparam logic [10:0] QUAD_YEAR3 = 11'd1096;

   // day of year of March 1 in a common year
   localparam logic [8:0] MARCH_COMMON = 9'd59;

   // first day of each month in a leap year, zero based
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0,   9'd31,  9'd60,  9'd91,  9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

endpackage

// ----- rtl/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00
// into Gregorian year, month, day, hour, minute and second.
//
//   Channel   Direction  Handshake           Payload
//   req       in         req_valid/stall     req_epoch_secs[31:0]
//   rsp       out        rsp_valid/stall     year, month, day, hour, min, sec
//
// Eleven register stages; one beat enters per cycle while req_stall is low.
// Each stage holds a valid bit; a stage loads when it is empty or the next
// stage loads, so bubbles close up while the response is stalled.
// Reset clears only the valid bits.
// Divisions by constants are reciprocal multiplies with one correction step.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_secs,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_year_full,
   output logic [3:0]  rsp_month_num,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute
);

   localparam int NS = esc_pkg::NUM_STAGES;

   // stage valid bits and load enables
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] rdy;

   // build the load chain from the output back
   assign rdy[NS-1] = !vld_ff[NS-1] || !rsp_stall;
   for (genvar s = 0; s < NS - 1; s++) begin : g_rdy
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end

   assign vld_in = {vld_ff[NS-2:0], req_valid};
   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NS-1];

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   // ---------------- stage 0: day count estimate ----------------
   logic [31:0] secs_s0_ff, secs_s0_in;
   logic [15:0] dq_s0_ff, dq_s0_in;
   logic [50:0] day_prod;

   always_comb begin
      day_prod   = 51'(req_epoch_secs[31:7]) * 51'(esc_pkg::RECIP_DAY);
      dq_s0_in   = day_prod[50:35];
      secs_s0_in = req_epoch_secs;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         secs_s0_ff <= secs_s0_in;
         dq_s0_ff   <= dq_s0_in;
      end
   end

   // ---------------- stage 1: remainder of the day estimate ----------------
   logic [15:0] dq_s1_ff, dq_s1_in;
   logic [17:0] drem_s1_ff, drem_s1_in;

   always_comb begin
      dq_s1_in   = dq_s0_ff;
      drem_s1_in = 18'(secs_s0_ff - (32'(dq_s0_ff) * 32'(esc_pkg::SECS_PER_DAY)));
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         dq_s1_ff   <= dq_s1_in;
         drem_s1_ff <= drem_s1_in;
      end
   end

   // ---------------- stage 2: correct day count and time of day ----------------
   logic [15:0] days_s2_ff, days_s2_in;
   logic [16:0] tod_s2_ff, tod_s2_in;

   always_comb begin
      if (drem_s1_ff >= 18'(esc_pkg::SECS_PER_DAY)) begin
         days_s2_in = dq_s1_ff + 16'd1;
         tod_s2_in  = 17'(drem_s1_ff - 18'(esc_pkg::SECS_PER_DAY));
      end else begin
         days_s2_in = dq_s1_ff;
         tod_s2_in  = drem_s1_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         days_s2_ff <= days_s2_in;
         tod_s2_ff  <= tod_s2_in;
      end
   end

   // ---------------- stage 3: shift to 1968 base, hour estimate ----------------
   logic [15:0] dp_s3_ff, dp_s3_in;
   logic [4:0]  hq_s3_ff, hq_s3_in;
   logic [16:0] tod_s3_ff, tod_s3_in;
   logic [25:0] hour_prod;

   always_comb begin
      // past February 2100 add the leap day that year lacks
      dp_s3_in = days_s2_ff + esc_pkg::BASE_OFFSET
               + 16'(days_s2_ff >= esc_pkg::SKIP_LEAP_DAY);
      hour_prod = 26'(tod_s2_ff[16:4]) * 26'(esc_pkg::RECIP_HOUR);
      hq_s3_in  = hour_prod[24:20];
      tod_s3_in = tod_s2_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         dp_s3_ff  <= dp_s3_in;
         hq_s3_ff  <= hq_s3_in;
         tod_s3_ff <= tod_s3_in;
      end
   end

   // ---------------- stage 4: four-year cycle estimate, hour remainder ----------------
   logic [15:0] dp_s4_ff, dp_s4_in;
   logic [5:0]  cq_s4_ff, cq_s4_in;
   logic [4:0]  hq_s4_ff, hq_s4_in;
   logic [12:0] hrem_s4_ff, hrem_s4_in;
   logic [31:0] quad_prod;

   always_comb begin
      quad_prod  = 32'(dp_s3_ff) * 32'(esc_pkg::RECIP_QUAD);
      cq_s4_in   = quad_prod[31:26];
      dp_s4_in   = dp_s3_ff;
      hq_s4_in   = hq_s3_ff;
      hrem_s4_in = 13'(tod_s3_ff - (17'(hq_s3_ff) * 17'(esc_pkg::SECS_PER_HOUR)));
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         dp_s4_ff   <= dp_s4_in;
         cq_s4_ff   <= cq_s4_in;
         hq_s4_ff   <= hq_s4_in;
         hrem_s4_ff <= hrem_s4_in;
      end
   end

   // ---------------- stage 5: cycle remainder, correct hour ----------------
   logic [5:0]  cq_s5_ff, cq_s5_in;
   logic [11:0] crem_s5_ff, crem_s5_in;
   logic [4:0]  hour_s5_ff, hour_s5_in;
   logic [11:0] mtod_s5_ff, mtod_s5_in;

   always_comb begin
      cq_s5_in   = cq_s4_ff;
      crem_s5_in = 12'(dp_s4_ff - (16'(cq_s4_ff) * 16'(esc_pkg::DAYS_PER_QUAD)));
      if (hrem_s4_ff >= 13'(esc_pkg::SECS_PER_HOUR)) begin
         hour_s5_in = hq_s4_ff + 5'd1;
         mtod_s5_in = 12'(hrem_s4_ff - 13'(esc_pkg::SECS_PER_HOUR));
      end else begin
         hour_s5_in = hq_s4_ff;
         mtod_s5_in = hrem_s4_ff[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         cq_s5_ff   <= cq_s5_in;
         crem_s5_ff <= crem_s5_in;
         hour_s5_ff <= hour_s5_in;
         mtod_s5_ff <= mtod_s5_in;
      end
   end

   // ---------------- stage 6: correct cycle, minute estimate ----------------
   logic [5:0]  cq_s6_ff, cq_s6_in;
   logic [10:0] cday_s6_ff, cday_s6_in;
   logic [4:0]  hour_s6_ff, hour_s6_in;
   logic [11:0] mtod_s6_ff, mtod_s6_in;
   logic [5:0]  mq_s6_ff, mq_s6_in;
   logic [22:0] min_prod;

   always_comb begin
      if (crem_s5_ff >= 12'(esc_pkg::DAYS_PER_QUAD)) begin
         cq_s6_in   = cq_s5_ff + 6'd1;
         cday_s6_in = 11'(crem_s5_ff - 12'(esc_pkg::DAYS_PER_QUAD));
      end else begin
         cq_s6_in   = cq_s5_ff;
         cday_s6_in = crem_s5_ff[10:0];
      end
      min_prod   = 23'(mtod_s5_ff[11:2]) * 23'(esc_pkg::RECIP_MIN);
      mq_s6_in   = min_prod[21:16];
      hour_s6_in = hour_s5_ff;
      mtod_s6_in = mtod_s5_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         cq_s6_ff   <= cq_s6_in;
         cday_s6_ff <= cday_s6_in;
         hour_s6_ff <= hour_s6_in;
         mtod_s6_ff <= mtod_s6_in;
         mq_s6_ff   <= mq_s6_in;
      end
   end

   // ---------------- stage 7: year and day of year, minute remainder ----------------
   logic [11:0] year_s7_ff, year_s7_in;
   logic [8:0]  doy_s7_ff, doy_s7_in;
   logic        leap_s7_ff, leap_s7_in;
   logic [4:0]  hour_s7_ff, hour_s7_in;
   logic [5:0]  mq_s7_ff, mq_s7_in;
   logic [6:0]  srem_s7_ff, srem_s7_in;
   logic [1:0]  yoff;

   always_comb begin
      // first year of each cycle is the leap year
      priority if (cday_s6_ff < esc_pkg::QUAD_YEAR1) begin
         yoff       = 2'd0;
         doy_s7_in  = cday_s6_ff[8:0];
         leap_s7_in = 1'b1;
      end else if (cday_s6_ff < esc_pkg::QUAD_YEAR2) begin
         yoff       = 2'd1;
         doy_s7_in  = 9'(cday_s6_ff - esc_pkg::QUAD_YEAR1);
         leap_s7_in = 1'b0;
      end else if (cday_s6_ff < esc_pkg::QUAD_YEAR3) begin
         yoff       = 2'd2;
         doy_s7_in  = 9'(cday_s6_ff - esc_pkg::QUAD_YEAR2);
         leap_s7_in = 1'b0;
      end else begin
         yoff       = 2'd3;
         doy_s7_in  = 9'(cday_s6_ff - esc_pkg::QUAD_YEAR3);
         leap_s7_in = 1'b0;
      end
      year_s7_in = esc_pkg::BASE_YEAR + {4'd0, cq_s6_ff, 2'b00} + 12'(yoff);
      hour_s7_in = hour_s6_ff;
      mq_s7_in   = mq_s6_ff;
      srem_s7_in = 7'(mtod_s6_ff - (12'(mq_s6_ff) * 12'(esc_pkg::SECS_PER_MIN)));
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         year_s7_ff <= year_s7_in;
         doy_s7_ff  <= doy_s7_in;
         leap_s7_ff <= leap_s7_in;
         hour_s7_ff <= hour_s7_in;
         mq_s7_ff   <= mq_s7_in;
         srem_s7_ff <= srem_s7_in;
      end
   end

   // ---------------- stage 8: map to leap calendar, correct minute ----------------
   logic [11:0] year_s8_ff, year_s8_in;
   logic [8:0]  doya_s8_ff, doya_s8_in;
   logic [4:0]  hour_s8_ff, hour_s8_in;
   logic [5:0]  min_s8_ff, min_s8_in;
   logic [5:0]  sec_s8_ff, sec_s8_in;

   always_comb begin
      // common years skip February 29
      if (!leap_s7_ff && (doy_s7_ff >= esc_pkg::MARCH_COMMON)) begin
         doya_s8_in = doy_s7_ff + 9'd1;
      end else begin
         doya_s8_in = doy_s7_ff;
      end
      if (srem_s7_ff >= esc_pkg::SECS_PER_MIN) begin
         min_s8_in = mq_s7_ff + 6'd1;
         sec_s8_in = 6'(srem_s7_ff - esc_pkg::SECS_PER_MIN);
      end else begin
         min_s8_in = mq_s7_ff;
         sec_s8_in = srem_s7_ff[5:0];
      end
      year_s8_in = year_s7_ff;
      hour_s8_in = hour_s7_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         year_s8_ff <= year_s8_in;
         doya_s8_ff <= doya_s8_in;
         hour_s8_ff <= hour_s8_in;
         min_s8_ff  <= min_s8_in;
         sec_s8_ff  <= sec_s8_in;
      end
   end

   // ---------------- stage 9: month lookup ----------------
   logic [11:0] year_s9_ff, year_s9_in;
   logic [8:0]  doya_s9_ff, doya_s9_in;
   logic [3:0]  mon_s9_ff, mon_s9_in;
   logic [4:0]  hour_s9_ff, hour_s9_in;
   logic [5:0]  min_s9_ff, min_s9_in;
   logic [5:0]  sec_s9_ff, sec_s9_in;

   always_comb begin
      // pick the last month whose first day is not past the day of year
      mon_s9_in = 4'd1;
      for (int k = 1; k < 12; k++) begin
         if (doya_s8_ff >= esc_pkg::MONTH_START[k]) begin
            mon_s9_in = 4'(k + 1);
         end
      end
      year_s9_in = year_s8_ff;
      doya_s9_in = doya_s8_ff;
      hour_s9_in = hour_s8_ff;
      min_s9_in  = min_s8_ff;
      sec_s9_in  = sec_s8_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[9]) begin
         year_s9_ff <= year_s9_in;
         doya_s9_ff <= doya_s9_in;
         mon_s9_ff  <= mon_s9_in;
         hour_s9_ff <= hour_s9_in;
         min_s9_ff  <= min_s9_in;
         sec_s9_ff  <= sec_s9_in;
      end
   end

   // ---------------- stage 10: day of month, output register ----------------
   logic [11:0] year_s10_ff, year_s10_in;
   logic [3:0]  mon_s10_ff, mon_s10_in;
   logic [4:0]  day_s10_ff, day_s10_in;
   logic [4:0]  hour_s10_ff, hour_s10_in;
   logic [5:0]  min_s10_ff, min_s10_in;
   logic [5:0]  sec_s10_ff, sec_s10_in;
   logic [3:0]  mon_idx;

   always_comb begin
      mon_idx     = mon_s9_ff - 4'd1;
      day_s10_in  = 5'(doya_s9_ff - esc_pkg::MONTH_START[mon_idx] + 9'd1);
      year_s10_in = year_s9_ff;
      mon_s10_in  = mon_s9_ff;
      hour_s10_in = hour_s9_ff;
      min_s10_in  = min_s9_ff;
      sec_s10_in  = sec_s9_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[10]) begin
         year_s10_ff <= year_s10_in;
         mon_s10_ff  <= mon_s10_in;
         day_s10_ff  <= day_s10_in;
         hour_s10_ff <= hour_s10_in;
         min_s10_ff  <= min_s10_in;
         sec_s10_ff  <= sec_s10_in;
      end
   end

   // drive the response beat
   assign rsp_year_full        = year_s10_ff;
   assign rsp_month_num        = mon_s10_ff;
   assign rsp_day_of_month     = day_s10_ff;
   assign rsp_hour_of_day      = hour_s10_ff;
   assign rsp_minute_of_hour   = min_s10_ff;
   assign rsp_second_of_minute = sec_s10_ff;

endmodule

// ----- tb/tb_epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking bench for the seconds-to-calendar converter. A behavioral
// calendar walk predicts year, month, day and time of day for every request
// beat taken by the block. Each response beat is compared field by field with
// the oldest prediction. Stimulus opens with boundary dates (epoch, top of
// range, leap days, skipped 2100 leap day), then random timestamps biased
// toward day, year and February edges. Both channels are throttled at
// random, and one long response hold fills the pipeline.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

   localparam int unsigned DAY_SECS   = 86400;
   localparam int unsigned HOUR_SECS  = 3600;
   localparam int unsigned MIN_SECS   = 60;
   localparam int unsigned FIRST_YEAR = 1970;
   localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                  31, 31, 30, 31, 30, 31};
   localparam int unsigned HOLD_CYCLES = 60;
   localparam int unsigned SETTLE_CYCLES = esc_pkg::NUM_STAGES + 8;

   typedef struct packed {
      logic [11:0] year_full;
      logic [3:0]  month_num;
      logic [4:0]  day_of_month;
      logic [4:0]  hour_of_day;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
   } calendar_type;

   // Predicts dates for accepted timestamps and matches them against responses
   class calendar_scoreboard;
      calendar_type pending_dates[$];
      int           error_count;

      function new();
         error_count = 0;
      endfunction

      function bit is_leap_year(int unsigned yr);
         return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
      endfunction

      // Walk whole years, then months, then split the time of day
      function calendar_type civil_from_epoch(logic [31:0] secs);
         int unsigned  days;
         int unsigned  tod;
         int unsigned  yr;
         int unsigned  year_len;
         int unsigned  mon;
         int unsigned  month_len;
         calendar_type date;
         days = secs / DAY_SECS;
         tod  = secs % DAY_SECS;
         yr   = FIRST_YEAR;
         year_len = is_leap_year(yr) ? 366 : 365;
         while (days >= year_len) begin
            days -= year_len;
            yr++;
            year_len = is_leap_year(yr) ? 366 : 365;
         end
         mon = 0;
         month_len = DAYS_IN_MONTH[0];
         while (days >= month_len) begin
            days -= month_len;
            mon++;
            month_len = (mon == 1 && is_leap_year(yr)) ? 29 : DAYS_IN_MONTH[mon];
         end
         date.year_full        = yr[11:0];
         date.month_num        = 4'(mon + 1);
         date.day_of_month     = 5'(days + 1);
         date.hour_of_day      = 5'(tod / HOUR_SECS);
         date.minute_of_hour   = 6'((tod % HOUR_SECS) / MIN_SECS);
         date.second_of_minute = 6'(tod % MIN_SECS);
         return date;
      endfunction

      function void note_request(logic [31:0] secs);
         pending_dates.push_back(civil_from_epoch(secs));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(calendar_type got);
         calendar_type want;
         if (pending_dates.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
            return;
         end
         want = pending_dates.pop_front();
         compare_field("year_full", want.year_full, got.year_full);
         compare_field("month_num", want.month_num, got.month_num);
         compare_field("day_of_month", want.day_of_month, got.day_of_month);
         compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
         compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
         compare_field("second_of_minute", want.second_of_minute,
                       got.second_of_minute);
      endfunction

      function bit drained();
         return pending_dates.size() == 0;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_epoch_secs = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year_full;
   logic [3:0]  rsp_month_num;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour_of_day;
   logic [5:0]  rsp_minute_of_hour;
   logic [5:0]  rsp_second_of_minute;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_grants = 0;
   int unsigned hold_taken = 0;
   int unsigned hold_left = 0;

   calendar_scoreboard sb = new();

   epoch_seconds_to_calendar dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_epoch_secs       (req_epoch_secs),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_year_full        (rsp_year_full),
      .rsp_month_num        (rsp_month_num),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Throttle the response side; a granted hold keeps stall high for a long run
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_grants != hold_taken) begin
         hold_taken <= hold_taken + 1;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Predict every request beat taken by the block
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_epoch_secs);
      end
   end

   // Check every response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response({rsp_year_full, rsp_month_num, rsp_day_of_month,
                            rsp_hour_of_day, rsp_minute_of_hour,
                            rsp_second_of_minute});
      end
   end

   // Idle each cycle with the sender's idle odds, then offer one beat;
   // return at the edge that takes it
   task automatic send_timestamp(logic [31:0] secs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_epoch_secs <= $urandom;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_epoch_secs <= secs;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Drop valid and hold until every predicted date has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (!sb.drained());
   endtask

   // Random timestamp biased toward day, year and February edges
   function automatic logic [31:0] random_timestamp();
      longint unsigned secs;
      int unsigned     yr;
      int unsigned     days;
      int unsigned     tod_pick [4];
      int unsigned     doy_pick [6];
      tod_pick = '{0, 1, DAY_SECS - 2, DAY_SECS - 1};
      doy_pick = '{0, 58, 59, 60, 364, 365};
      case ($urandom_range(5))
         0: secs = $urandom;
         1: secs = longint'($urandom_range(49710)) * DAY_SECS
                   + tod_pick[$urandom_range(3)];
         2: begin
            yr   = $urandom_range(FIRST_YEAR, 2106);
            days = 0;
            for (int unsigned y = FIRST_YEAR; y < yr; y++) begin
               days += sb.is_leap_year(y) ? 366 : 365;
            end
            days += doy_pick[$urandom_range(5)];
            secs = longint'(days) * DAY_SECS + tod_pick[$urandom_range(3)];
         end
         3: secs = 32'hFFFF_FFFF - $urandom_range(200000);
         4: secs = $urandom_range(100_000_000);
         default: secs = $urandom & $urandom;
      endcase
      if (secs > 64'h0000_0000_FFFF_FFFF) begin
         secs = 64'h0000_0000_FFFF_FFFF;
      end
      return secs[31:0];
   endfunction

   // Epoch, top of range, year and leap-day edges, 2100 skipped leap day
   logic [31:0] boundary_times [20] = '{
      32'd0,          32'd1,          32'd59,         32'd86399,
      32'd86400,      32'd31535999,   32'd68169600,   32'd946684799,
      32'd946684800,  32'd951782399,  32'd951782400,  32'd951868800,
      32'd978220800,  32'd4107542399, 32'd4107542400, 32'h7FFF_FFFF,
      32'h8000_0000,  32'hAAAA_AAAA,  32'h5555_5555,  32'hFFFF_FFFF
   };

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (boundary_times[i]) begin
         send_timestamp(boundary_times[i]);
      end
      wait_for_drain();

      // sender idles lightly, receiver heavily
      send_idle_pct <= 30;
      recv_idle_pct <= 52;
      @(posedge clock);
      repeat (270) send_timestamp(random_timestamp());
      wait_for_drain();

      // roles swapped
      send_idle_pct <= 52;
      recv_idle_pct <= 30;
      @(posedge clock);
      repeat (270) send_timestamp(random_timestamp());

      // long response hold while requests keep coming, so the pipe backs up
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_grants   <= hold_grants + 1;
      repeat (40) send_timestamp(random_timestamp());
      wait_for_drain();

      // full rate on both sides
      repeat (250) send_timestamp(random_timestamp());
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- epoch_seconds_to_calendar.f -----
rtl/esc_pkg.sv
rtl/epoch_seconds_to_calendar.sv
tb/tb_epoch_seconds_to_calendar.sv
